// ----- sv/kfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfl_pkg
// shared types and constants of the keyed free list cell store
// ----------------------------------------------------------------------------
package kfl_pkg;

   localparam int Cells     = 256;
   localparam int AddrWidth = 8;
   localparam int LinkWidth = 9;
   localparam int CountWidth = 9;

   localparam logic [2:0] ACT_ALLOC = 3'd0;
   localparam logic [2:0] ACT_FREE  = 3'd1;
   localparam logic [2:0] ACT_READ  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_PROBE = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_OOM      = 2'd2;

   localparam logic [LinkWidth-1:0] NilLink = LinkWidth'(Cells);

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         addr;
      logic [63:0]        key;
      logic signed [31:0] value;
      logic               last_key;
   } req_type;

   typedef struct packed {
      logic [7:0]         cell_addr;
      logic [7:0]         head_addr;
      logic signed [31:0] data;
      logic [1:0]         status;
      logic               is_free;
      logic [8:0]         free_count;
      logic [8:0]         used_count;
   } rsp_type;

endpackage

// ----- sv/kfl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module kfl_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- sv/kfl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfl_front
// input queue: takes request words and holds them for the engine
// ----------------------------------------------------------------------------
module kfl_front
   import kfl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    q_valid,
   input  logic    q_take,
   output req_type q_word
);

   req_type    buf_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_word    = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wp_ff] <= req_word;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ----- sv/kfl_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfl_engine
// cell store engine: clearing pass, allocate, chain walks and probe
// ----------------------------------------------------------------------------
module kfl_engine
   import kfl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_take,
   input  req_type q_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_ALOC_RD, S_ALOC_WR, S_ALOC_TAIL,
      S_WALK_RD, S_WALK_CHK, S_FREE_END, S_RESP
   } state_type;

   state_type            state_ff;
   logic [AddrWidth-1:0] init_ff;
   req_type              cur_ff;
   logic [LinkWidth-1:0] free_head_ff;
   logic [CountWidth-1:0] free_total_ff;
   logic [AddrWidth-1:0] rec_head_ff, rec_tail_ff, x_ff, tail_ff;
   logic                 in_rec_ff, hit_ff;
   logic [CountWidth-1:0] n_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic [Cells-1:0]     free_bits_ff;

   logic                 mem_we_link, mem_we_key, mem_we_data;
   logic [AddrWidth-1:0] mem_addr;
   logic [LinkWidth-1:0] link_wd, link_rd;
   logic [63:0]          key_rd;
   logic [31:0]          data_rd;

   kfl_ram #(.Width(LinkWidth), .Depth(Cells)) u_link (
      .clock(clock), .wr_en(mem_we_link), .addr(mem_addr),
      .wr_data(link_wd), .rd_data(link_rd));
   kfl_ram #(.Width(64), .Depth(Cells)) u_key (
      .clock(clock), .wr_en(mem_we_key), .addr(mem_addr),
      .wr_data(state_ff == S_INIT ? 64'd0 : cur_ff.key), .rd_data(key_rd));
   kfl_ram #(.Width(32), .Depth(Cells)) u_data (
      .clock(clock), .wr_en(mem_we_data), .addr(mem_addr),
      .wr_data(state_ff == S_INIT ? 32'd0 : 32'(cur_ff.value)), .rd_data(data_rd));

   logic used_x;
   assign used_x = !free_bits_ff[x_ff];

   always_comb begin
      mem_we_link = 1'b0;
      mem_we_key  = 1'b0;
      mem_we_data = 1'b0;
      mem_addr    = x_ff;
      link_wd     = NilLink;
      case (state_ff)
         S_INIT: begin
            mem_addr    = init_ff;
            mem_we_link = 1'b1;
            mem_we_key  = 1'b1;
            mem_we_data = 1'b1;
            link_wd     = LinkWidth'(init_ff) + LinkWidth'(1);
         end
         S_ALOC_RD: mem_addr = free_head_ff[AddrWidth-1:0];
         S_ALOC_WR: begin
            mem_addr    = free_head_ff[AddrWidth-1:0];
            mem_we_link = 1'b1;
            mem_we_key  = 1'b1;
         end
         S_ALOC_TAIL: begin
            mem_addr    = rec_tail_ff;
            mem_we_link = 1'b1;
            link_wd     = LinkWidth'(x_ff);
         end
         S_WALK_CHK: begin
            mem_addr    = x_ff;
            mem_we_data = (cur_ff.action == ACT_WRITE) && (key_rd == cur_ff.key);
         end
         S_FREE_END: begin
            mem_addr    = tail_ff;
            mem_we_link = 1'b1;
            link_wd     = free_head_ff;
         end
         default: ;
      endcase
   end

   assign q_take    = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_ff       <= '0;
         free_head_ff  <= '0;
         free_total_ff <= CountWidth'(Cells);
         rec_head_ff   <= '0;
         rec_tail_ff   <= '0;
         in_rec_ff     <= 1'b0;
         free_bits_ff  <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + AddrWidth'(1);
               if (init_ff == AddrWidth'(Cells - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid && !rsp_valid_ff) begin
                  cur_ff <= q_word;
                  x_ff   <= q_word.addr;
                  tail_ff <= q_word.addr;
                  n_ff   <= '0;
                  hit_ff <= 1'b0;
                  rsp_ff <= '0;
                  case (q_word.action)
                     ACT_ALLOC: state_ff <= S_ALOC_RD;
                     ACT_FREE: state_ff <=
                        free_bits_ff[q_word.addr] ? S_RESP : S_WALK_RD;
                     ACT_READ, ACT_WRITE: state_ff <= S_WALK_RD;
                     ACT_PROBE: begin
                        rsp_ff.is_free <= free_bits_ff[q_word.addr];
                        state_ff <= S_RESP;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_ALOC_RD: begin
               if (free_head_ff >= NilLink) begin
                  rsp_ff.status <= ST_OOM;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_ALOC_WR;
               end
            end
            S_ALOC_WR: begin
               x_ff <= free_head_ff[AddrWidth-1:0];
               free_head_ff <= link_rd;
               free_bits_ff[free_head_ff[AddrWidth-1:0]] <= 1'b0;
               free_total_ff <= free_total_ff - CountWidth'(1);
               rsp_ff.cell_addr <= free_head_ff[AddrWidth-1:0];
               rsp_ff.head_addr <= in_rec_ff ? rec_head_ff
                                             : free_head_ff[AddrWidth-1:0];
               if (!in_rec_ff) rec_head_ff <= free_head_ff[AddrWidth-1:0];
               state_ff <= in_rec_ff ? S_ALOC_TAIL : S_RESP;
               if (!in_rec_ff) begin
                  rec_tail_ff <= free_head_ff[AddrWidth-1:0];
                  in_rec_ff <= !cur_ff.last_key;
               end
            end
            S_ALOC_TAIL: begin
               rec_tail_ff <= x_ff;
               in_rec_ff <= !cur_ff.last_key;
               state_ff <= S_RESP;
            end
            S_WALK_RD: begin
               if (!used_x || n_ff == CountWidth'(Cells)) begin
                  if (cur_ff.action == ACT_FREE) state_ff <= S_FREE_END;
                  else begin
                     rsp_ff.status <= hit_ff ? ST_OK : ST_NOTFOUND;
                     state_ff <= S_RESP;
                  end
               end else begin
                  state_ff <= S_WALK_CHK;
               end
            end
            S_WALK_CHK: begin
               n_ff <= n_ff + CountWidth'(1);
               x_ff <= link_rd[AddrWidth-1:0];
               state_ff <= S_WALK_RD;
               if (link_rd >= NilLink) begin
                  x_ff <= x_ff;
               end
               if (cur_ff.action == ACT_FREE) begin
                  free_bits_ff[x_ff] <= 1'b1;
                  tail_ff <= x_ff;
                  if (in_rec_ff && x_ff == rec_tail_ff) in_rec_ff <= 1'b0;
                  if (link_rd >= NilLink) state_ff <= S_FREE_END;
               end else if (key_rd == cur_ff.key) begin
                  hit_ff <= 1'b1;
                  if (cur_ff.action == ACT_READ) begin
                     rsp_ff.data <= data_rd;
                     rsp_ff.status <= ST_OK;
                     state_ff <= S_RESP;
                  end
               end
               if (cur_ff.action != ACT_FREE && link_rd >= NilLink &&
                   !(cur_ff.action == ACT_READ && key_rd == cur_ff.key)) begin
                  rsp_ff.status <= (hit_ff || key_rd == cur_ff.key)
                                   ? ST_OK : ST_NOTFOUND;
                  state_ff <= S_RESP;
               end
            end
            S_FREE_END: begin
               free_head_ff <= LinkWidth'(cur_ff.addr);
               free_total_ff <= free_total_ff + n_ff;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.free_count <= free_total_ff;
                  rsp_ff.used_count <= CountWidth'(Cells) - free_total_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= CountWidth'(Cells)) else $error("free count too large");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == S_IDLE) else $error("take outside idle");
   a_rsp_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.free_count + rsp_ff.used_count == CountWidth'(Cells))
      else $error("counts inconsistent");
`endif

endmodule

// ----- sv/keyed_free_list_cell_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_free_list_cell_store
// pool of linked keyed cells with a free list
// ----------------------------------------------------------------------------
// latency to rsp_valid by states: probe, unused codes, free of a free cell: S_RESP;
// out of memory: S_ALOC_RD, S_RESP; allocate: S_ALOC_RD, S_ALOC_WR, S_ALOC_TAIL in a record,
// S_RESP; read/write: S_WALK_RD, S_WALK_CHK per chain cell, S_RESP; free adds S_FREE_END
// throughput: one word at a time, the next is taken the cycle after the response leaves
// after reset a clearing pass over all 256 cells runs before the first word is taken
// ----------------------------------------------------------------------------
module keyed_free_list_cell_store
   import kfl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic    q_valid, q_take;
   req_type q_word;

   kfl_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_word(req_word), .q_valid(q_valid), .q_take(q_take), .q_word(q_word));

   kfl_engine u_engine (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_word(q_word), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_word(rsp_word));

endmodule
